// File: rtl/dtse_pkg.sv
`default_nettype none

package dtse_pkg;

   // Field widths fixed by the item layout
   localparam int ELEM_W  = 64;
   localparam int EXT_W   = 16;
   localparam int LVL_W   = 2;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam int DEF_MAX_DIMS   = 4;
   localparam int DEF_COORD_BITS = 16;

   // Sparse formats
   localparam logic [1:0] FMT_COO = 2'd0;
   localparam logic [1:0] FMT_CSR = 2'd1;
   localparam logic [1:0] FMT_CSC = 2'd2;
   localparam logic [1:0] FMT_CSF = 2'd3;

   // Element kinds for the zero test
   localparam logic [1:0] VF_INT    = 2'd0;
   localparam logic [1:0] VF_HALF   = 2'd1;
   localparam logic [1:0] VF_SINGLE = 2'd2;
   localparam logic [1:0] VF_DOUBLE = 2'd3;

   // Result word kinds
   localparam logic [1:0] KIND_VALUE   = 2'd0;
   localparam logic [1:0] KIND_INDEX   = 2'd1;
   localparam logic [1:0] KIND_POINTER = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPARSE_FORMAT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_COUNT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_0      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_2      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_3      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_AXES    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_VALUE_FORMAT  = 3'd7;

   // Register reset values
   localparam logic [1:0] RST_SPARSE_FORMAT = 2'd0;
   localparam logic [2:0] RST_DIM_COUNT     = 3'd2;
   localparam logic [EXT_W-1:0] RST_EXTENT  = 16'd1;
   localparam logic [7:0] RST_LEVEL_AXES    = 8'd228;
   localparam logic [1:0] RST_VALUE_FORMAT  = 2'd0;

   // Datapath commands
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_ACCEPT   = 4'd1;
   localparam logic [3:0] OP_LEAD_PTR = 4'd2;
   localparam logic [3:0] OP_VALUE    = 4'd3;
   localparam logic [3:0] OP_COO_IDX  = 4'd4;
   localparam logic [3:0] OP_MAT_IDX  = 4'd5;
   localparam logic [3:0] OP_CSF_PTR  = 4'd6;
   localparam logic [3:0] OP_CSF_IDX  = 4'd7;
   localparam logic [3:0] OP_ROW_PTR  = 4'd8;
   localparam logic [3:0] OP_TAIL_PTR = 4'd9;
   localparam logic [3:0] OP_FINISH   = 4'd10;

   typedef struct packed {
      logic [3:0]       op;
      logic [LVL_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic       in_nz;      // element on the request port is nonzero
      logic       nz;         // accepted element is nonzero
      logic [1:0] fmt;
      logic [2:0] n;          // levels in use
      logic       need_lead;
      logic       need_row;
      logic       need_tail;
      logic       last;
      logic       split_now;  // CSF level at cmd.idx opens a new branch
      logic       can_push;   // a result word may be generated this cycle
   } status_type;

endpackage

`default_nettype wire

// File: rtl/dtse_ctrl.sv
`default_nettype none

module dtse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  dtse_pkg::status_type     status,
   output dtse_pkg::cmd_type        cmd
);
   import dtse_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LEAD = 3'd1;
   localparam logic [2:0] S_VAL  = 3'd2;
   localparam logic [2:0] S_IDX  = 3'd3;
   localparam logic [2:0] S_ROW  = 3'd4;
   localparam logic [2:0] S_TAIL = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [LVL_W-1:0] i_ff, i_in;
   logic             sub_ff, sub_in;
   logic             last_i;
   logic             tail_end;

   // First stage after 'from' that has work for this item
   function automatic logic [2:0] pick(input logic [2:0] from, input logic nz,
                                       input status_type st);
      logic [2:0] s;
      begin
         if (from < S_LEAD && st.need_lead)      s = S_LEAD;
         else if (from < S_VAL && nz)            s = S_VAL;
         else if (from < S_IDX && nz)            s = S_IDX;
         else if (from < S_ROW && st.need_row)   s = S_ROW;
         else if (from < S_TAIL && st.need_tail) s = S_TAIL;
         else                                    s = S_FIN;
         return s;
      end
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign last_i    = ((3'(i_ff) + 3'd1) == status.n);
   assign tail_end  = ((3'(i_ff) + 3'd2) == status.n);

   // Step sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      sub_in   = sub_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = pick(S_IDLE, status.in_nz, status);
               i_in     = '0;
               sub_in   = 1'b0;
            end
         end
         S_LEAD: begin
            if (status.can_push) begin
               cmd.op   = OP_LEAD_PTR;
               state_in = pick(S_LEAD, status.nz, status);
            end
         end
         S_VAL: begin
            if (status.can_push) begin
               cmd.op   = OP_VALUE;
               state_in = pick(S_VAL, status.nz, status);
            end
         end
         S_IDX: begin
            case (status.fmt)
               FMT_COO: begin
                  if (status.can_push) begin
                     cmd.op = OP_COO_IDX;
                     if (last_i) begin
                        i_in     = '0;
                        state_in = pick(S_IDX, status.nz, status);
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end
               end
               FMT_CSF: begin
                  if (!status.split_now) begin
                     // level unchanged since the previous nonzero
                     if (last_i) begin
                        i_in     = '0;
                        state_in = pick(S_IDX, status.nz, status);
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else if (status.can_push) begin
                     if (!sub_ff && !last_i) begin
                        cmd.op = OP_CSF_PTR;
                        sub_in = 1'b1;
                     end else begin
                        cmd.op = OP_CSF_IDX;
                        sub_in = 1'b0;
                        if (last_i) begin
                           i_in     = '0;
                           state_in = pick(S_IDX, status.nz, status);
                        end else begin
                           i_in = i_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  if (status.can_push) begin
                     cmd.op   = OP_MAT_IDX;
                     state_in = pick(S_IDX, status.nz, status);
                  end
               end
            endcase
         end
         S_ROW: begin
            if (status.can_push) begin
               cmd.op   = OP_ROW_PTR;
               state_in = pick(S_ROW, status.nz, status);
            end
         end
         S_TAIL: begin
            if (status.can_push) begin
               cmd.op = OP_TAIL_PTR;
               if (status.fmt != FMT_CSF || tail_end) begin
                  i_in     = '0;
                  state_in = S_FIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            if (status.can_push) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         sub_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/dtse_datapath.sv
`default_nettype none

module dtse_datapath #(
   parameter int DIM_CAP    = dtse_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = dtse_pkg::DEF_COORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [dtse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dtse_pkg::CSR_W-1:0]        csr_data,
   input  wire logic [dtse_pkg::ELEM_W-1:0]       req_element_bits,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_word_kind,
   output logic [dtse_pkg::LVL_W-1:0]             rsp_level,
   output logic [dtse_pkg::ELEM_W-1:0]            rsp_word,
   output logic                                   rsp_run_end,
   output logic                                   rsp_tensor_end,
   input  dtse_pkg::cmd_type                      cmd,
   output dtse_pkg::status_type                   status
);
   import dtse_pkg::*;

   localparam int IDX_W = $clog2(DIM_CAP);
   localparam int CMP_W = ((COORD_BITS > EXT_W) ? COORD_BITS : EXT_W) + 1;
   localparam logic [2:0] CAP3 = 3'(DIM_CAP);

   // Configuration
   logic [1:0]       fmt_ff;
   logic [2:0]       dims_ff;
   logic [EXT_W-1:0] ext_ff [4];
   logic [7:0]       axes_ff;
   logic [1:0]       vfmt_ff;

   // Walk state
   logic [COORD_BITS-1:0] pos_ff   [DIM_CAP];
   logic [COORD_BITS-1:0] prior_ff [DIM_CAP];
   logic [COORD_BITS-1:0] pos_adv  [DIM_CAP];
   logic [ELEM_W-1:0]     cnt_ff   [DIM_CAP];
   logic                  prior_valid_ff;
   logic [ELEM_W-1:0]     total_ff;
   logic                  started_ff;

   // Accepted item
   logic [ELEM_W-1:0] elem_ff;
   logic              nz_ff;
   logic              split_ff;

   // Pending word and output register
   logic              pend_valid_ff;
   logic [1:0]        pend_kind_ff;
   logic [LVL_W-1:0]  pend_level_ff;
   logic [ELEM_W-1:0] pend_word_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [LVL_W-1:0]  rsp_level_ff;
   logic [ELEM_W-1:0] rsp_word_ff;
   logic              rsp_run_end_ff;
   logic              rsp_tensor_end_ff;

   logic [2:0]        n;
   logic [IDX_W-1:0]  ord [DIM_CAP];
   logic [DIM_CAP-1:0] wrap;
   logic              last;
   logic              mat;
   logic [IDX_W-1:0]  idx, idx1;
   logic              out_free, can_push;
   logic              gen_valid;
   logic [1:0]        gen_kind;
   logic [LVL_W-1:0]  gen_level;
   logic [ELEM_W-1:0] gen_word;

   function automatic logic is_zero(input logic [ELEM_W-1:0] v, input logic [1:0] vf);
      logic z;
      begin
         unique case (vf)
            VF_HALF:   z = (v[14:0] == '0);
            VF_SINGLE: z = (v[30:0] == '0);
            VF_DOUBLE: z = (v[62:0] == '0);
            default:   z = (v == '0);
         endcase
         return z;
      end
   endfunction

   assign mat  = (fmt_ff == FMT_CSR) || (fmt_ff == FMT_CSC);
   assign idx  = cmd.idx[IDX_W-1:0];
   assign idx1 = idx + 1'b1;

   // Level count and axis order
   always_comb begin
      logic [3:0] seen;
      logic       ok;
      logic [1:0] a;
      seen = '0;
      ok   = 1'b1;
      if (fmt_ff == FMT_COO) begin
         n = (dims_ff == 3'd0) ? 3'd1 : ((dims_ff > CAP3) ? CAP3 : dims_ff);
      end else if (fmt_ff == FMT_CSF) begin
         n = (dims_ff < 3'd2) ? 3'd2 : ((dims_ff > CAP3) ? CAP3 : dims_ff);
      end else begin
         n = 3'd2;
      end
      for (int i = 0; i < DIM_CAP; i++) begin
         a = axes_ff[2*i +: 2];
         if (3'(i) < n) begin
            if ({1'b0, a} >= n || seen[a]) ok = 1'b0;
            seen[a] = 1'b1;
         end
      end
      for (int i = 0; i < DIM_CAP; i++) begin
         a = axes_ff[2*i +: 2];
         ord[i] = IDX_W'(i);
         if (fmt_ff == FMT_CSF && ok) ord[i] = a[IDX_W-1:0];
      end
      if (fmt_ff == FMT_CSC) begin
         ord[0] = IDX_W'(1);
         ord[1] = IDX_W'(0);
      end
   end

   // Per-axis wrap test
   always_comb begin
      for (int a = 0; a < DIM_CAP; a++) begin
         wrap[a] = (pos_ff[a] == {COORD_BITS{1'b1}})
                || ((CMP_W'(pos_ff[a]) + CMP_W'(1)) >= CMP_W'(ext_ff[a]));
      end
   end

   always_comb begin
      last = 1'b1;
      for (int i = 0; i < DIM_CAP; i++) begin
         if (3'(i) < n && !wrap[ord[i]]) last = 1'b0;
      end
   end

   // Odometer advance in walk order, innermost level first
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int a = 0; a < DIM_CAP; a++) pos_adv[a] = pos_ff[a];
      for (int j = DIM_CAP - 1; j >= 0; j--) begin
         if (3'(j) < n && carry) begin
            if (wrap[ord[j]]) begin
               pos_adv[ord[j]] = '0;
            end else begin
               pos_adv[ord[j]] = pos_ff[ord[j]] + 1'b1;
               carry = 1'b0;
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_push = !pend_valid_ff || out_free;

   always_comb begin
      status.in_nz     = !is_zero(req_element_bits, vfmt_ff);
      status.nz        = nz_ff;
      status.fmt       = fmt_ff;
      status.n         = n;
      status.need_lead = mat && !started_ff;
      status.need_row  = mat && wrap[ord[1]];
      status.need_tail = last && (fmt_ff == FMT_COO || fmt_ff == FMT_CSF);
      status.last      = last;
      status.split_now = split_ff || (pos_ff[ord[idx]] != prior_ff[ord[idx]]);
      status.can_push  = can_push;
   end

   // Result word selection
   always_comb begin
      gen_valid = 1'b1;
      gen_kind  = KIND_POINTER;
      gen_level = LVL_W'(idx);
      gen_word  = '0;
      unique case (cmd.op)
         OP_LEAD_PTR: begin
            gen_level = (fmt_ff == FMT_CSR) ? 2'd0 : 2'd1;
         end
         OP_VALUE: begin
            gen_kind  = KIND_VALUE;
            gen_level = '0;
            gen_word  = elem_ff;
         end
         OP_COO_IDX: begin
            gen_kind = KIND_INDEX;
            gen_word = ELEM_W'(pos_ff[idx]);
         end
         OP_MAT_IDX: begin
            gen_kind = KIND_INDEX;
            if (fmt_ff == FMT_CSR) begin
               gen_level = 2'd1;
               gen_word  = ELEM_W'(pos_ff[1]);
            end else begin
               gen_level = 2'd0;
               gen_word  = ELEM_W'(pos_ff[0]);
            end
         end
         OP_CSF_PTR: begin
            gen_word = cnt_ff[idx1];
         end
         OP_CSF_IDX: begin
            gen_kind = KIND_INDEX;
            gen_word = ELEM_W'(pos_ff[ord[idx]]);
         end
         OP_ROW_PTR: begin
            gen_level = (fmt_ff == FMT_CSR) ? 2'd0 : 2'd1;
            gen_word  = total_ff;
         end
         OP_TAIL_PTR: begin
            if (fmt_ff == FMT_COO) begin
               gen_level = '0;
               gen_word  = total_ff;
            end else begin
               gen_word = cnt_ff[idx1];
            end
         end
         default: gen_valid = 1'b0;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= RST_SPARSE_FORMAT;
         dims_ff <= RST_DIM_COUNT;
         for (int k = 0; k < 4; k++) ext_ff[k] <= RST_EXTENT;
         axes_ff <= RST_LEVEL_AXES;
         vfmt_ff <= RST_VALUE_FORMAT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SPARSE_FORMAT: fmt_ff    <= csr_data[1:0];
            REG_DIM_COUNT:     dims_ff   <= csr_data[2:0];
            REG_EXTENT_0:      ext_ff[0] <= csr_data;
            REG_EXTENT_1:      ext_ff[1] <= csr_data;
            REG_EXTENT_2:      ext_ff[2] <= csr_data;
            REG_EXTENT_3:      ext_ff[3] <= csr_data;
            REG_LEVEL_AXES:    axes_ff   <= csr_data[7:0];
            REG_VALUE_FORMAT:  vfmt_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Walk state, counters and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIM_CAP; k++) begin
            pos_ff[k]   <= '0;
            prior_ff[k] <= '0;
            cnt_ff[k]   <= '0;
         end
         prior_valid_ff <= 1'b0;
         total_ff       <= '0;
         started_ff     <= 1'b0;
         split_ff       <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_ACCEPT:  split_ff <= !prior_valid_ff;
            OP_VALUE:   total_ff <= total_ff + 1'b1;
            OP_CSF_IDX: begin
               cnt_ff[idx] <= cnt_ff[idx] + 1'b1;
               split_ff    <= 1'b1;
            end
            OP_FINISH: begin
               if (last) begin
                  for (int k = 0; k < DIM_CAP; k++) begin
                     pos_ff[k]   <= '0;
                     prior_ff[k] <= '0;
                     cnt_ff[k]   <= '0;
                  end
                  prior_valid_ff <= 1'b0;
                  total_ff       <= '0;
                  started_ff     <= 1'b0;
               end else begin
                  for (int k = 0; k < DIM_CAP; k++) pos_ff[k] <= pos_adv[k];
                  started_ff <= 1'b1;
                  if (fmt_ff == FMT_CSF && nz_ff) begin
                     for (int k = 0; k < DIM_CAP; k++) prior_ff[k] <= pos_ff[k];
                     prior_valid_ff <= 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         elem_ff <= req_element_bits;
         nz_ff   <= !is_zero(req_element_bits, vfmt_ff);
      end
   end

   // One word is held back so the last word of an item can carry run_end
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (gen_valid) pend_valid_ff <= 1'b1;
         else if (cmd.op == OP_FINISH) pend_valid_ff <= 1'b0;
         if ((gen_valid || cmd.op == OP_FINISH) && pend_valid_ff) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_valid) begin
         pend_kind_ff  <= gen_kind;
         pend_level_ff <= gen_level;
         pend_word_ff  <= gen_word;
      end
      if ((gen_valid || cmd.op == OP_FINISH) && pend_valid_ff) begin
         rsp_kind_ff       <= pend_kind_ff;
         rsp_level_ff      <= pend_level_ff;
         rsp_word_ff       <= pend_word_ff;
         rsp_run_end_ff    <= (cmd.op == OP_FINISH);
         rsp_tensor_end_ff <= (cmd.op == OP_FINISH) && last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_kind  = rsp_kind_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_tensor_end = rsp_tensor_end_ff;

endmodule

`default_nettype wire

// File: rtl/dense_to_sparse_tensor_encoder.sv
// Dense-to-sparse tensor encoder (COO, CSR, CSC, CSF).
// Request channel: req_valid / req_stall / req_element_bits, one dense element per
// item, in the walk order of the selected format. Result channel: rsp_valid /
// rsp_stall with word kind, level, word, run_end and tensor_end; an element gives
// zero to eleven result words, the last of them flagged run_end, and the final
// word of a tensor also flagged tensor_end.
// Registers are written through csr_write / csr_index / csr_data while idle;
// the user must keep to this, as the block does not enforce it. One item at a
// time: the sequencer accepts it, then forms in order the lead pointer, value,
// index and CSF pointer, row pointer and tail pointer words that apply, one word
// per cycle while there is room, steps over each CSF level whose coordinate is
// unchanged, then finishes. One word is held back so that run_end can be marked:
// a word reaches rsp_valid when the item's next word is formed or it finishes.
// Reset (synchronous) restores the register defaults and clears the walk state.
// While the receiver stalls, the held word and the output register fill up and
// the sequencer waits; req_stall stays high until the item is complete.
`default_nettype none

module dense_to_sparse_tensor_encoder #(
   parameter int MAX_DIMS   = dtse_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = dtse_pkg::DEF_COORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [dtse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dtse_pkg::CSR_W-1:0]        csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [dtse_pkg::ELEM_W-1:0]       req_element_bits,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_word_kind,
   output logic [dtse_pkg::LVL_W-1:0]             rsp_level,
   output logic [dtse_pkg::ELEM_W-1:0]            rsp_word,
   output logic                                   rsp_run_end,
   output logic                                   rsp_tensor_end
);
   import dtse_pkg::*;

   localparam int DIM_CAP = (MAX_DIMS < 4) ? MAX_DIMS : 4;

   cmd_type    cmd;
   status_type status;

   dtse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dtse_datapath #(
      .DIM_CAP    (DIM_CAP),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_element_bits (req_element_bits),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_word_kind    (rsp_word_kind),
      .rsp_level        (rsp_level),
      .rsp_word         (rsp_word),
      .rsp_run_end      (rsp_run_end),
      .rsp_tensor_end   (rsp_tensor_end),
      .cmd              (cmd),
      .status           (status)
   );

   // An item is taken only by the accept command
   a_accept_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd.op == OP_ACCEPT))
      else $error("item accepted without accept command");

   // Result words are formed only when there is room for them
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LEAD_PTR || cmd.op == OP_VALUE || cmd.op == OP_COO_IDX ||
       cmd.op == OP_MAT_IDX || cmd.op == OP_CSF_PTR || cmd.op == OP_CSF_IDX ||
       cmd.op == OP_ROW_PTR || cmd.op == OP_TAIL_PTR) |-> status.can_push)
      else $error("result word formed without room");

   // Finishing an item frees the request side next cycle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |=> !req_stall)
      else $error("request side not free after item finished");

endmodule

`default_nettype wire
